/* hw/rtl/dpc_pkg.sv */
package dpc_pkg;

    localparam int DPC_MAX_CUBES = 256;
    localparam int CUBE_W        = 9;
    localparam int COUNT_W       = 64;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic   valid;
        count_t way_count;
        logic   out_of_range;
    } dpc_result_t;

endpackage

/* hw/rtl/dpc_table_ram.sv */
module dpc_table_ram
    import dpc_pkg::*;
#(
    parameter int DEPTH = DPC_MAX_CUBES + 1,
    parameter int AW    = $clog2(DPC_MAX_CUBES + 1)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  count_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output count_t        rd_data_a,
    output count_t        rd_data_b
);

    count_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* hw/rtl/dpc_engine.sv */
module dpc_engine
    import dpc_pkg::*;
#(
    parameter int MAX_CUBES = DPC_MAX_CUBES,
    parameter int AW        = $clog2(DPC_MAX_CUBES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] total,
    input  logic          too_big,
    output logic          busy,
    output dpc_result_t   result
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_OOR   = 5'b00010,
        S_CLEAR = 5'b00100,
        S_RUN   = 5'b01000,
        S_LAST  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] total_reg, total_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] part_reg, part_next;
    logic [AW-1:0] n_reg, n_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          fwd_a_reg, fwd_a_next;
    logic          fwd_b_reg, fwd_b_next;
    count_t        fwd_data_reg, fwd_data_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    count_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    count_t        rd_data_a;
    count_t        rd_data_b;
    count_t        op_a;
    count_t        op_b;
    count_t        sum;

    dpc_table_ram #(
        .DEPTH (MAX_CUBES + 1),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // the one shared adder, with bypass of the write that lands on a read
    assign op_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
    assign op_b = fwd_b_reg ? fwd_data_reg : rd_data_b;
    assign sum  = op_a + op_b;

    assign rd_addr_a = n_reg;
    assign rd_addr_b = n_reg - part_reg;
    assign rd_en     = (state_reg == S_RUN);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = sum;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = (clr_reg == '0) ? count_t'(1) : '0;
        end
        else if (pend_reg)
        begin
            wr_en = 1'b1;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        clr_next       = clr_reg;
        part_next      = part_reg;
        n_next         = n_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        fwd_a_next     = 1'b0;
        fwd_b_next     = 1'b0;
        fwd_data_next  = sum;
        result         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    total_next = total;
                    clr_next   = '0;
                    state_next = too_big ? S_OOR : S_CLEAR;
                end
            end
            S_OOR:
            begin
                result.valid        = 1'b1;
                result.out_of_range = 1'b1;
                state_next          = S_IDLE;
            end
            S_CLEAR:
            begin
                if (clr_reg == total_reg)
                begin
                    if (total_reg == '0)
                    begin
                        result.valid     = 1'b1;
                        result.way_count = count_t'(1);
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        part_next  = AW'(1);
                        n_next     = total_reg;
                        state_next = S_RUN;
                    end
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_RUN:
            begin
                pend_next      = 1'b1;
                pend_addr_next = n_reg;
                fwd_a_next     = pend_reg && (pend_addr_reg == rd_addr_a);
                fwd_b_next     = pend_reg && (pend_addr_reg == rd_addr_b);
                if (n_reg == part_reg)
                begin
                    if (part_reg == total_reg)
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        part_next = part_reg + AW'(1);
                        n_next    = total_reg;
                    end
                end
                else
                begin
                    n_next = n_reg - AW'(1);
                end
            end
            S_LAST:
            begin
                result.valid     = 1'b1;
                result.way_count = sum;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            fwd_a_reg <= fwd_a_next;
            fwd_b_reg <= fwd_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg     <= total_next;
        clr_reg       <= clr_next;
        part_reg      <= part_next;
        n_reg         <= n_next;
        pend_addr_reg <= pend_addr_next;
        fwd_data_reg  <= fwd_data_next;
    end

endmodule

/* hw/rtl/distinct_partition_counter.sv */
// N + 1 table entries are cleared first, then N*(N+1)/2 add steps run at one per cycle
// through the shared adder and the two-read table memory, then a final drain state
// zero totals skip the add steps, and out-of-range totals skip the table clear as well
// one transaction at a time; the next is taken once the engine is idle and no stalled result is held
// reset: asynchronous, clears control only; the table is swept clear at each in-range transaction
module distinct_partition_counter
    import dpc_pkg::*;
#(
    parameter int MAX_CUBES = DPC_MAX_CUBES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CUBE_W-1:0] cube_count,
    output logic              out_valid,
    input  logic              out_stall,
    output count_t            way_count,
    output logic              out_of_range
);

    localparam int AW = $clog2(MAX_CUBES + 1);
    localparam logic [CUBE_W+1:0] LIMIT = (CUBE_W + 2)'(MAX_CUBES);

    logic          busy;
    logic          start;
    logic          too_big;
    logic [AW-1:0] total;
    dpc_result_t   result;

    logic          out_valid_reg;
    count_t        way_count_reg;
    logic          out_of_range_reg;

    assign in_stall = busy || (out_valid_reg && out_stall);
    assign start    = in_valid && !in_stall;
    assign too_big  = {2'b00, cube_count} > LIMIT;
    assign total    = AW'(cube_count);

    dpc_engine #(
        .MAX_CUBES (MAX_CUBES),
        .AW        (AW)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .total   (total),
        .too_big (too_big),
        .busy    (busy),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            way_count_reg    <= result.way_count;
            out_of_range_reg <= result.out_of_range;
        end
    end

    assign out_valid    = out_valid_reg;
    assign way_count    = way_count_reg;
    assign out_of_range = out_of_range_reg;

endmodule

/* test/distinct_partition_counter_test.sv */
module distinct_partition_counter_test;
    import dpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned RANDOM_PER_PHASE = 18;

    typedef struct {
        logic [CUBE_W-1:0] total;
        count_t            way_count;
        logic              out_of_range;
    } partition_result_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CUBE_W-1:0] cube_count = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    count_t            way_count;
    logic              out_of_range;

    partition_result_t owed_results[$];
    int unsigned       error_count = 0;
    int unsigned       gap_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       totals_taken = 0;
    int unsigned       oversized_taken = 0;
    int unsigned       largest_counted = 0;

    distinct_partition_counter dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cube_count   (cube_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .way_count    (way_count),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // knapsack over distinct part sizes, one table per total
    function automatic partition_result_t predict_ways(input logic [CUBE_W-1:0] total);
        count_t            ways [0:DPC_MAX_CUBES];
        partition_result_t r;
        int                part;
        int                n;
        r.total = total;
        if (total > DPC_MAX_CUBES)
        begin
            r.way_count    = '0;
            r.out_of_range = 1'b1;
            return r;
        end
        for (n = 0; n <= DPC_MAX_CUBES; n++)
        begin
            ways[n] = '0;
        end
        ways[0] = count_t'(1);
        for (part = 1; part <= int'(total); part++)
        begin
            for (n = int'(total); n >= part; n--)
            begin
                ways[n] = ways[n] + ways[n - part];
            end
        end
        r.way_count    = ways[total];
        r.out_of_range = 1'b0;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // record every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            owed_results.push_back(predict_ways(cube_count));
            totals_taken++;
            if (cube_count > DPC_MAX_CUBES)
                oversized_taken++;
            else if (cube_count > largest_counted)
                largest_counted = 32'(cube_count);
        end
    end

    always @(posedge clk)
    begin : check_results
        partition_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result way_count=%0d out_of_range=%0b",
                    way_count, out_of_range));
            end
            else
            begin
                want = owed_results.pop_front();
                if (way_count !== want.way_count)
                    flag_mismatch($sformatf("total %0d: way_count %0d, want %0d",
                        want.total, way_count, want.way_count));
                if (out_of_range !== want.out_of_range)
                    flag_mismatch($sformatf("total %0d: out_of_range %b, want %b",
                        want.total, out_of_range, want.out_of_range));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("distinct_partition_counter_test: done, errors");
        $finish;
    end

    // one input transaction, with an optional random gap before it
    task automatic send_total(input logic [CUBE_W-1:0] total);
        int unsigned gap;
        gap = 0;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cube_count <= total;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // mostly small totals to keep the run short, a few large, some oversized
    task automatic send_random_totals(input int unsigned count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_total(CUBE_W'($urandom_range(40)));
            else if (pick < 75)
                send_total(CUBE_W'($urandom_range(120, 41)));
            else if (pick < 80)
                send_total(CUBE_W'($urandom_range(DPC_MAX_CUBES, 121)));
            else
                send_total(CUBE_W'($urandom_range(511, DPC_MAX_CUBES + 1)));
        end
    endtask

    task automatic test_edge_totals();
        logic [CUBE_W-1:0] edge_totals [] = '{0, 1, 2, 3, 4, 5, 7, 8, 16, 100,
            255, 256, 257, 258, 300, 384, 510, 511, 0, 256, 1};
        gap_pct   = 0;
        stall_pct = 0;
        foreach (edge_totals[i])
            send_total(edge_totals[i]);
        wait_for_drain();
    endtask

    task automatic test_no_idle();
        gap_pct   = 0;
        stall_pct = 0;
        send_random_totals(RANDOM_PER_PHASE);
        wait_for_drain();
    endtask

    task automatic test_sender_gaps();
        gap_pct   = 51;
        stall_pct = 0;
        send_random_totals(RANDOM_PER_PHASE);
        wait_for_drain();
    endtask

    task automatic test_receiver_stalls();
        gap_pct   = 0;
        stall_pct = 51;
        send_random_totals(RANDOM_PER_PHASE);
        wait_for_drain();
    endtask

    task automatic test_both_idle();
        gap_pct   = 25;
        stall_pct = 25;
        send_random_totals(RANDOM_PER_PHASE);
        wait_for_drain();
    endtask

    // sender holds off until everything owed has come back
    task automatic test_paused_sender();
        gap_pct   = 0;
        stall_pct = 25;
        repeat (3)
        begin
            send_random_totals(3);
            wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_totals();
        test_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_paused_sender();

        repeat (8) @(posedge clk);
        while (owed_results.size() != 0)
        begin
            flag_mismatch($sformatf("no result for total %0d",
                owed_results.pop_front().total));
        end

        $display("covered %0d totals, %0d above the bound, largest counted total %0d",
            totals_taken, oversized_taken, largest_counted);
        $display("phases: edge totals, no idling, sender gaps, receiver stalls, both, pauses");
        if (error_count == 0)
            $display("distinct_partition_counter_test: done, clean");
        else
            $display("distinct_partition_counter_test: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/dpc_pkg.sv
hw/rtl/dpc_table_ram.sv
hw/rtl/dpc_engine.sv
hw/rtl/distinct_partition_counter.sv
test/distinct_partition_counter_test.sv
